[rtl/frame_timing_statistics_assert.svh]
// Assertion macros for the frame timing statistics RTL.
`ifndef FRAME_TIMING_STATISTICS_ASSERT_SVH
`define FRAME_TIMING_STATISTICS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define FTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame timing statistics: assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define FTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame timing statistics: assertion failed");
`else
`define FTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/fts_pkg.sv]
// Types and constants shared by the frame timing statistics block.
package fts_pkg;

  localparam int DUR_W   = 32;
  localparam int COUNT_W = 48;
  localparam int LANES   = 3;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_ERROR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Lane 0 is compose, lane 1 graphics wait, lane 2 video wait.
  typedef struct packed {
    cmd_e                         command;
    logic [LANES-1:0][DUR_W-1:0]  dur;
    logic                         late_frame;
  } item_t;

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] frame_count;
    logic [DUR_W-1:0]   average_compose;
    logic [DUR_W-1:0]   average_gpu_wait;
    logic [DUR_W-1:0]   average_video_wait;
    logic [DUR_W-1:0]   peak_compose;
    logic [DUR_W-1:0]   peak_gpu_wait;
    logic [DUR_W-1:0]   peak_video_wait;
    logic [COUNT_W-1:0] missed_deadlines;
    logic [COUNT_W-1:0] error_count;
  } snapshot_t;

endpackage

[rtl/fts_divider.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
module fts_divider #(
  parameter int DIVIDEND_BITS = 64,
  parameter int DIVISOR_BITS  = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]  divisor_i,
  output logic                     done_o,
  output logic [fts_pkg::DUR_W-1:0] quotient_o
);
  import fts_pkg::*;

  localparam int CW = $clog2(DIVIDEND_BITS + 1);

  logic                     busy_q;
  logic                     done_q;
  logic [CW-1:0]            cnt_q;
  logic [DIVIDEND_BITS-1:0] dvd_q;
  logic [DIVISOR_BITS-1:0]  dvs_q;
  logic [DIVISOR_BITS-1:0]  rem_q;
  logic [DUR_W-1:0]         quo_q;

  logic [DIVISOR_BITS:0] shifted;
  logic [DIVISOR_BITS:0] diff;
  logic                  fits;

  assign shifted = {rem_q, dvd_q[DIVIDEND_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIVIDEND_BITS);
      end
    end
  end

  // The remainder stays below the divisor, so its low bits carry it fully.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[DUR_W-2:0], fits};
    end else if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      quo_q <= '0;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/fts_engine.sv]
// Statistics state and the sequencer that updates it and drives the divider.
module fts_engine #(
  parameter int COUNTER_BITS = 48,
  parameter int SUM_BITS     = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  fts_pkg::item_t      req_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output fts_pkg::snapshot_t  res_o
);
  import fts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_APPLY,
    S_DSTART,
    S_DWAIT,
    S_DONE
  } state_e;

  localparam logic [1:0] LAST_LANE = 2'(LANES - 1);

  state_e                  state_q;
  logic [1:0]              lane_q;
  item_t                   item_q;
  logic                    ovf_q;
  logic                    status_q;
  logic [COUNTER_BITS-1:0] frames_q;
  logic [COUNTER_BITS-1:0] misses_q;
  logic [COUNTER_BITS-1:0] errors_q;
  logic [SUM_BITS-1:0]     sum_q  [LANES];
  logic [SUM_BITS-1:0]     nsum_q [LANES];
  logic [DUR_W-1:0]        peak_q [LANES];
  logic [DUR_W-1:0]        avg_q  [LANES];

  logic [SUM_BITS:0]  add_res;
  logic               reject;
  logic               div_start;
  logic               div_done;
  logic [DUR_W-1:0]   div_quot;

  // One wide add per cycle; the carry out marks a total that would overflow.
  assign add_res = {1'b0, sum_q[lane_q]} + (SUM_BITS + 1)'(item_q.dur[lane_q]);

  assign reject = ovf_q || (frames_q == {COUNTER_BITS{1'b1}}) ||
                  (item_q.late_frame && (misses_q == {COUNTER_BITS{1'b1}}));

  assign div_start = (state_q == S_DSTART) && (frames_q != '0);

  fts_divider #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (COUNTER_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[lane_q]),
    .divisor_i  (frames_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lane_q   <= '0;
      item_q   <= '0;
      ovf_q    <= 1'b0;
      status_q <= 1'b0;
      frames_q <= '0;
      misses_q <= '0;
      errors_q <= '0;
      for (int k = 0; k < LANES; k++) begin
        sum_q[k]  <= '0;
        nsum_q[k] <= '0;
        peak_q[k] <= '0;
        avg_q[k]  <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            item_q   <= req_i;
            lane_q   <= '0;
            ovf_q    <= 1'b0;
            status_q <= 1'b0;
            state_q  <= (req_i.command == CMD_FRAME) ? S_CHECK : S_APPLY;
          end
        end
        S_CHECK: begin
          nsum_q[lane_q] <= add_res[SUM_BITS-1:0];
          ovf_q          <= ovf_q | add_res[SUM_BITS];
          if (lane_q == LAST_LANE) begin
            state_q <= S_APPLY;
          end else begin
            lane_q <= lane_q + 1'b1;
          end
        end
        S_APPLY: begin
          lane_q  <= '0;
          state_q <= S_DSTART;
          unique case (item_q.command)
            CMD_FRAME: begin
              if (reject) begin
                status_q <= 1'b1;
              end else begin
                frames_q <= frames_q + 1'b1;
                if (item_q.late_frame) begin
                  misses_q <= misses_q + 1'b1;
                end
                for (int k = 0; k < LANES; k++) begin
                  sum_q[k]  <= nsum_q[k];
                  peak_q[k] <= (item_q.dur[k] > peak_q[k]) ? item_q.dur[k] : peak_q[k];
                end
              end
            end
            CMD_ERROR: begin
              if (errors_q != {COUNTER_BITS{1'b1}}) begin
                errors_q <= errors_q + 1'b1;
              end
            end
            CMD_READ: begin
            end
            CMD_CLEAR: begin
              frames_q <= '0;
              misses_q <= '0;
              errors_q <= '0;
              for (int k = 0; k < LANES; k++) begin
                sum_q[k]  <= '0;
                peak_q[k] <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        S_DSTART: begin
          // With no frames recorded every average reads as zero.
          if (frames_q == '0) begin
            for (int k = 0; k < LANES; k++) begin
              avg_q[k] <= '0;
            end
            state_q <= S_DONE;
          end else begin
            state_q <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            avg_q[lane_q] <= div_quot;
            if (lane_q == LAST_LANE) begin
              state_q <= S_DONE;
            end else begin
              lane_q  <= lane_q + 1'b1;
              state_q <= S_DSTART;
            end
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.status             = status_q;
    res_o.frame_count        = COUNT_W'(frames_q);
    res_o.average_compose    = avg_q[0];
    res_o.average_gpu_wait   = avg_q[1];
    res_o.average_video_wait = avg_q[2];
    res_o.peak_compose       = peak_q[0];
    res_o.peak_gpu_wait      = peak_q[1];
    res_o.peak_video_wait    = peak_q[2];
    res_o.missed_deadlines   = COUNT_W'(misses_q);
    res_o.error_count        = COUNT_W'(errors_q);
  end

endmodule

[rtl/frame_timing_statistics.sv]
// Frame timing statistics block: stream ports, result register and checks.
// Each beat carries one command and is answered by exactly one snapshot beat.
// One item occupies the block for its whole run: a frame record goes through
// overflow check and update (one 64-bit add per duration), any other command
// through the update alone, then the three averages go one after another
// through a single restoring divider at one quotient bit per cycle, followed
// by the hand-over of the snapshot. While no frame has been recorded the
// divisions are skipped. A snapshot that finds the output register still
// full holds the block until it can be handed over. The next beat is
// accepted while the previous snapshot still waits in the output register.
`include "frame_timing_statistics_assert.svh"

module frame_timing_statistics #(
  parameter int COUNTER_BITS = 48,
  parameter int SUM_BITS     = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // compose_time, gpu_wait_time, video_wait_time, late_frame, zero pad
  input  logic [103:0] s_axis_tdata_i,
  // command
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // status, frame_count, average_compose, average_gpu_wait,
  // average_video_wait, peak_compose, peak_gpu_wait, peak_video_wait,
  // missed_deadlines, error_count, zero pad
  output logic [343:0] m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);
  import fts_pkg::*;

  item_t     req;
  snapshot_t res;
  snapshot_t out_q;
  logic      out_valid_q;
  logic      eng_ready;
  logic      res_valid;
  logic      res_ready;
  logic      in_beat;
  logic      res_beat;

  always_comb begin
    req.command    = cmd_e'(s_axis_tuser_i);
    req.dur[0]     = s_axis_tdata_i[31:0];
    req.dur[1]     = s_axis_tdata_i[63:32];
    req.dur[2]     = s_axis_tdata_i[95:64];
    req.late_frame = s_axis_tdata_i[96];
  end

  fts_engine #(
    .COUNTER_BITS (COUNTER_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (eng_ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign s_axis_tready_o = eng_ready;
  assign in_beat         = s_axis_tvalid_i && eng_ready;
  assign res_ready       = !out_valid_q || m_axis_tready_i;
  assign res_beat        = res_valid && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_beat) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0,
                            out_q.error_count,
                            out_q.missed_deadlines,
                            out_q.peak_video_wait,
                            out_q.peak_gpu_wait,
                            out_q.peak_compose,
                            out_q.average_video_wait,
                            out_q.average_gpu_wait,
                            out_q.average_compose,
                            out_q.frame_count,
                            out_q.status};

  // The block works on one item at a time.
  `FTS_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_beat, !s_axis_tready_o)
  // A snapshot handed over by the engine is always shown on the next cycle.
  `FTS_ASSERT_NXT(a_result_lands, clk_i, rst_ni, res_beat, m_axis_tvalid_o)
  // The output register fills only from an engine hand-over.
  `FTS_ASSERT_IMP(a_fill_source, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(res_beat))
  // A finished snapshot never coexists with acceptance of a new beat.
  `FTS_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, res_valid, !s_axis_tready_o)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the frame timing statistics block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fts_pkg::*;

  localparam int          RANDOM_ITEMS = 400;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          PRINT_CAP    = 40;
  localparam logic [47:0] COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [31:0] DUR_MAX      = {DUR_W{1'b1}};

  typedef struct {
    cmd_e        cmd;
    logic [31:0] compose;
    logic [31:0] gpu_wait;
    logic [31:0] video_wait;
    logic        missed;
    bit          typed;
    snapshot_t   typed_snapshot;
  } stim_row_t;

  typedef logic [63:0] field_set_t [10];

  logic         clk;
  logic         rst_n;
  logic [103:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         s_tvalid;
  logic         s_tready;
  logic [343:0] m_tdata;
  logic         m_tvalid;
  logic         m_tready;

  // Own copy of the statistics kept by the block.
  logic [47:0] frames_ct;
  logic [47:0] miss_ct;
  logic [47:0] err_ct;
  logic [63:0] sum_q  [3];
  logic [31:0] peak_q [3];

  snapshot_t expected_snapshots [$];
  stim_row_t directed_rows [$];

  int  mismatches;
  int  snapshots_checked;
  int  cycle_count;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  cmd_tally [4];
  int  directed_sent;
  int  random_sent;
  bit  random_started;
  logic rx_hold;

  string field_names [10] = '{"status", "frame_count", "average_compose", "average_gpu_wait",
                              "average_video_wait", "peak_compose", "peak_gpu_wait",
                              "peak_video_wait", "missed_deadlines", "error_count"};

  frame_timing_statistics DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic snapshot_t make_snapshot(logic [47:0] fc, logic [31:0] ac, logic [31:0] ag,
                                              logic [31:0] av, logic [31:0] pc, logic [31:0] pg,
                                              logic [31:0] pv, logic [47:0] md, logic [47:0] ec);
    snapshot_t s;
    s.status             = 1'b0;
    s.frame_count        = fc;
    s.average_compose    = ac;
    s.average_gpu_wait   = ag;
    s.average_video_wait = av;
    s.peak_compose       = pc;
    s.peak_gpu_wait      = pg;
    s.peak_video_wait    = pv;
    s.missed_deadlines   = md;
    s.error_count        = ec;
    return s;
  endfunction

  // Carries out one command on the local statistics and returns the snapshot that follows.
  function automatic snapshot_t predict_snapshot(stim_row_t r);
    snapshot_t   s;
    logic [31:0] d    [3];
    logic [64:0] wide [3];
    logic [63:0] avg  [3];
    logic        overflow;
    d[0] = r.compose;
    d[1] = r.gpu_wait;
    d[2] = r.video_wait;
    s = '0;
    case (r.cmd)
      CMD_FRAME: begin
        overflow = (frames_ct == COUNT_MAX) || (r.missed && miss_ct == COUNT_MAX);
        for (int i = 0; i < 3; i++) begin
          wide[i] = {1'b0, sum_q[i]} + {33'b0, d[i]};
          overflow = overflow | wide[i][64];
        end
        // A rejected record leaves every total, peak and count untouched.
        if (overflow) begin
          s.status = 1'b1;
        end else begin
          frames_ct = frames_ct + 48'd1;
          for (int i = 0; i < 3; i++) begin
            sum_q[i] = wide[i][63:0];
            if (d[i] > peak_q[i]) peak_q[i] = d[i];
          end
          if (r.missed) miss_ct = miss_ct + 48'd1;
        end
      end
      CMD_ERROR: begin
        if (err_ct != COUNT_MAX) err_ct = err_ct + 48'd1;
      end
      CMD_CLEAR: begin
        frames_ct = '0;
        miss_ct   = '0;
        err_ct    = '0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i]  = '0;
          peak_q[i] = '0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) avg[i] = (frames_ct == 0) ? 64'd0 : sum_q[i] / {16'b0, frames_ct};
    s.frame_count        = frames_ct;
    s.average_compose    = avg[0][31:0];
    s.average_gpu_wait   = avg[1][31:0];
    s.average_video_wait = avg[2][31:0];
    s.peak_compose       = peak_q[0];
    s.peak_gpu_wait      = peak_q[1];
    s.peak_video_wait    = peak_q[2];
    s.missed_deadlines   = miss_ct;
    s.error_count        = err_ct;
    return s;
  endfunction

  function automatic snapshot_t unpack_snapshot(logic [343:0] d);
    snapshot_t s;
    s.status             = d[0];
    s.frame_count        = d[48:1];
    s.average_compose    = d[80:49];
    s.average_gpu_wait   = d[112:81];
    s.average_video_wait = d[144:113];
    s.peak_compose       = d[176:145];
    s.peak_gpu_wait      = d[208:177];
    s.peak_video_wait    = d[240:209];
    s.missed_deadlines   = d[288:241];
    s.error_count        = d[336:289];
    return s;
  endfunction

  function automatic field_set_t split_fields(snapshot_t s);
    field_set_t f;
    f[0] = {63'b0, s.status};
    f[1] = {16'b0, s.frame_count};
    f[2] = {32'b0, s.average_compose};
    f[3] = {32'b0, s.average_gpu_wait};
    f[4] = {32'b0, s.average_video_wait};
    f[5] = {32'b0, s.peak_compose};
    f[6] = {32'b0, s.peak_gpu_wait};
    f[7] = {32'b0, s.peak_video_wait};
    f[8] = {16'b0, s.missed_deadlines};
    f[9] = {16'b0, s.error_count};
    return f;
  endfunction

  task automatic add_row(cmd_e cmd, logic [31:0] c, logic [31:0] g, logic [31:0] v,
                         logic m, bit typed, snapshot_t snap);
    stim_row_t r;
    r.cmd            = cmd;
    r.compose        = c;
    r.gpu_wait       = g;
    r.video_wait     = v;
    r.missed         = m;
    r.typed          = typed;
    r.typed_snapshot = snap;
    directed_rows.push_back(r);
  endtask

  // Offers one beat, possibly after an idle gap, and files its expected snapshot on acceptance.
  task automatic send_item(stim_row_t r);
    snapshot_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd;
    s_tdata  <= {7'b0, r.missed, r.video_wait, r.gpu_wait, r.compose};
    do @(posedge clk); while (!s_tready);
    predicted = predict_snapshot(r);
    expected_snapshots.push_back(r.typed ? r.typed_snapshot : predicted);
    cmd_tally[r.cmd]++;
  endtask

  function automatic logic [31:0] rand_duration();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DUR_MAX;
      2, 3, 4: return $urandom_range(20000000, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 60)      r.cmd = CMD_FRAME;
    else if (pick < 72) r.cmd = CMD_ERROR;
    else if (pick < 92) r.cmd = CMD_READ;
    else                r.cmd = CMD_CLEAR;
    r.compose        = rand_duration();
    r.gpu_wait       = rand_duration();
    r.video_wait     = rand_duration();
    r.missed         = ($urandom_range(3) == 0);
    r.typed          = 1'b0;
    r.typed_snapshot = '0;
    return r;
  endfunction

  // Result side: random back-pressure, plus one long hold-off during the random part.
  initial begin
    snapshot_t  got;
    snapshot_t  want;
    field_set_t got_f;
    field_set_t want_f;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && m_tvalid && m_tready) begin
        got = unpack_snapshot(m_tdata);
        if (expected_snapshots.size() == 0) begin
          report("snapshot beat arrived with nothing expected");
        end else begin
          want   = expected_snapshots.pop_front();
          got_f  = split_fields(got);
          want_f = split_fields(want);
          for (int i = 0; i < 10; i++) begin
            if (got_f[i] !== want_f[i])
              report($sformatf("snapshot %0d field %s got 0x%0h expected 0x%0h",
                               snapshots_checked, field_names[i], got_f[i], want_f[i]));
          end
          snapshots_checked++;
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    rx_hold = 1'b0;
    wait (random_started);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout with %0d snapshots still expected", expected_snapshots.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    s_tvalid       = 1'b0;
    s_tuser        = CMD_READ;
    s_tdata        = '0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    random_started = 1'b0;
    frames_ct      = '0;
    miss_ct        = '0;
    err_ct         = '0;
    for (int i = 0; i < 3; i++) begin
      sum_q[i]  = '0;
      peak_q[i] = '0;
    end

    // cmd, compose, gpu wait, video wait, missed, typed, expected snapshot
    add_row(CMD_READ,  '0,           '0,           '0,           1'b0, 1'b1, '0);
    add_row(CMD_ERROR, DUR_MAX,      DUR_MAX,      DUR_MAX,      1'b1, 1'b1,
            make_snapshot(48'd1 - 48'd1, 0, 0, 0, 0, 0, 0, 48'd0, 48'd1));
    add_row(CMD_FRAME, DUR_MAX,      DUR_MAX,      DUR_MAX,      1'b1, 1'b1,
            make_snapshot(48'd1, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX,
                          48'd1, 48'd1));
    add_row(CMD_FRAME, '0,           '0,           '0,           1'b0, 1'b0, '0);
    add_row(CMD_READ,  DUR_MAX,      DUR_MAX,      DUR_MAX,      1'b1, 1'b0, '0);
    add_row(CMD_CLEAR, DUR_MAX,      DUR_MAX,      DUR_MAX,      1'b1, 1'b1, '0);
    add_row(CMD_READ,  '0,           '0,           '0,           1'b0, 1'b1, '0);
    add_row(CMD_FRAME, 32'd1,        32'd2,        32'd3,        1'b0, 1'b1,
            make_snapshot(48'd1, 32'd1, 32'd2, 32'd3, 32'd1, 32'd2, 32'd3, 48'd0, 48'd0));
    add_row(CMD_FRAME, 32'hAAAAAAAA, 32'h55555555, 32'h80000000, 1'b1, 1'b0, '0);
    add_row(CMD_FRAME, 32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFF, 1'b0, 1'b0, '0);
    add_row(CMD_ERROR, 32'h0000FFFF, '0,           32'hFFFF0000, 1'b0, 1'b0, '0);
    add_row(CMD_ERROR, '0,           '0,           '0,           1'b1, 1'b0, '0);
    add_row(CMD_READ,  32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1'b0, 1'b0, '0);
    add_row(CMD_CLEAR, '0,           '0,           '0,           1'b0, 1'b1, '0);
    add_row(CMD_ERROR, '0,           '0,           '0,           1'b0, 1'b1,
            make_snapshot(48'd0, 0, 0, 0, 0, 0, 0, 48'd0, 48'd1));
    add_row(CMD_CLEAR, '0,           '0,           '0,           1'b0, 1'b1, '0);
    add_row(CMD_FRAME, DUR_MAX,      DUR_MAX,      DUR_MAX,      1'b0, 1'b1,
            make_snapshot(48'd1, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX,
                          48'd0, 48'd0));
    add_row(CMD_FRAME, 32'd7,        32'd0,        DUR_MAX,      1'b1, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
      directed_sent++;
    end

    random_started = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 26;
        rx_idle_pct = 65;
      end else if (n < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 65;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_item(random_row());
      random_sent++;
    end
    s_tvalid <= 1'b0;

    while (expected_snapshots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random beats: %0d frame, %0d error, %0d read, %0d clear",
             directed_sent, random_sent, cmd_tally[CMD_FRAME], cmd_tally[CMD_ERROR],
             cmd_tally[CMD_READ], cmd_tally[CMD_CLEAR]);
    $display("%0d snapshots compared field by field, %0d mismatches, %0d cycles",
             snapshots_checked, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/fts_pkg.sv
rtl/fts_divider.sv
rtl/fts_engine.sv
rtl/frame_timing_statistics.sv
tb/testbench.sv
